### rtl/isort_pkg.sv
// Shared types for the insertion sorter: controller states and control/status bundles.
package isort_pkg;

	// Controller states: load values into the row, then stream the row out
	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} isort_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic insert;  // insert the accepted request value into the row
		logic shift;   // drop the head entry after an output request is taken
	} isort_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic last_entry;  // exactly one entry remains in the row
	} isort_status_t;

endpackage

### rtl/isort_dp.sv
// Datapath of the insertion sorter: ordered compare-and-shift row, fill count, overflow flag.
module isort_dp #(
	parameter int DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  isort_pkg::isort_cmd_t cmd,
	output isort_pkg::isort_status_t status,
	input  logic signed [31:0]    sample_value,
	output logic signed [31:0]    sorted_value,
	output logic                  end_of_set,
	output logic                  overflowed
);
	import isort_pkg::*;

	localparam int FW = $clog2(DEPTH + 1);
	localparam logic [FW-1:0] FULL_LEVEL = FW'(DEPTH);

	logic signed [31:0] store_q [DEPTH];
	logic signed [31:0] store_d [DEPTH];
	logic [DEPTH-1:0]   gt;
	logic [FW-1:0]      fill_q;
	logic               ovf_q;
	logic               full;

	assign full = (fill_q == FULL_LEVEL);

	// Compare the incoming value against every valid entry in parallel
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (FW'(i) < fill_q) && (sample_value < store_q[i]);
		end
	end

	// Next row contents: shift left on output, open a slot and insert on input
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			store_d[i] = store_q[i];
			if (cmd.shift) begin
				if (i < DEPTH - 1) begin
					store_d[i] = store_q[(i + 1) % DEPTH];
				end
			end else if (cmd.insert && !full) begin
				if (i > 0 && gt[(i + DEPTH - 1) % DEPTH]) begin
					store_d[i] = store_q[(i + DEPTH - 1) % DEPTH];
				end else if (gt[i] || FW'(i) == fill_q) begin
					store_d[i] = sample_value;
				end
			end
		end
	end

	// Hold the row contents
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			store_q[i] <= store_d[i];
		end
	end

	// Track fill count and overflow for the current set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.shift) begin
			fill_q <= fill_q - FW'(1);
			if (fill_q == FW'(1)) begin
				ovf_q <= 1'b0;
			end
		end else if (cmd.insert) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				fill_q <= fill_q + FW'(1);
			end
		end
	end

	assign status.last_entry = (fill_q == FW'(1));
	assign sorted_value      = store_q[0];
	assign end_of_set        = status.last_entry;
	assign overflowed        = ovf_q;

endmodule

### rtl/isort_ctrl.sv
// Controller of the insertion sorter: load/emit sequencing and handshake control.
module isort_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     final_item,
	output logic                     in_ready,
	output logic                     out_valid,
	input  logic                     out_ready,
	input  isort_pkg::isort_status_t status,
	output isort_pkg::isort_cmd_t    cmd
);
	import isort_pkg::*;

	isort_state_t state_q;
	isort_state_t state_d;

	// Next state: go emit after the final request, return after the last result
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid && final_item) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_ready && status.last_entry) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Outputs: handshakes and datapath commands
	always_comb begin
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		cmd.insert = 1'b0;
		cmd.shift  = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready   = 1'b1;
				cmd.insert = in_valid;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				cmd.shift = out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/insertion_sorter.sv
// Top level of the insertion sorter: controller and compare-and-shift datapath.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, sample_value, final_item   | request in
//  out     | out_valid, out_ready, sorted_value, end_of_set,| request out
//          | overflowed                                     |
//
// Loading accepts each valid value: a parallel compare-and-shift row inserts
// each accepted value in the cycle it arrives. After a final value, the set is
// streamed out one result per cycle from the row head while out_ready is high;
// no input is taken during this time. Reset empties the row at once (fill count
// and overflow flag cleared). Stalls on out_ready simply hold the current head.
module insertion_sorter #(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] sample_value,
	input  logic               final_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] sorted_value,
	output logic               end_of_set,
	output logic               overflowed
);
	import isort_pkg::*;

	isort_cmd_t    cmd;
	isort_status_t status;

	// Sequence load and emit phases
	isort_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.final_item(final_item),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Hold the ordered row
	isort_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.sample_value(sample_value),
		.sorted_value(sorted_value),
		.end_of_set  (end_of_set),
		.overflowed  (overflowed)
	);

endmodule
